// ===== sv/hrlp_pkg.sv =====
// ----------------------------------------------------------------------------
// hrlp_pkg
// Shared types, codes and byte classes for the request line parser.
// ----------------------------------------------------------------------------
package hrlp_pkg;

    typedef enum logic [17:0] {
        PH_START  = 18'b00_0000_0000_0000_0001,
        PH_METHOD = 18'b00_0000_0000_0000_0010,
        PH_SP_URI = 18'b00_0000_0000_0000_0100,
        PH_SLASH  = 18'b00_0000_0000_0000_1000,
        PH_CHECK  = 18'b00_0000_0000_0001_0000,
        PH_URI    = 18'b00_0000_0000_0010_0000,
        PH_V09    = 18'b00_0000_0000_0100_0000,
        PH_H      = 18'b00_0000_0000_1000_0000,
        PH_HT     = 18'b00_0000_0001_0000_0000,
        PH_HTT    = 18'b00_0000_0010_0000_0000,
        PH_HTTP   = 18'b00_0000_0100_0000_0000,
        PH_MAJ1   = 18'b00_0000_1000_0000_0000,
        PH_MAJ    = 18'b00_0001_0000_0000_0000,
        PH_MIN1   = 18'b00_0010_0000_0000_0000,
        PH_MIN    = 18'b00_0100_0000_0000_0000,
        PH_SP_END = 18'b00_1000_0000_0000_0000,
        PH_ALMOST = 18'b01_0000_0000_0000_0000,
        PH_DONE   = 18'b10_0000_0000_0000_0000
    } t_phase;

    typedef enum logic [2:0] {
        ERR_NONE   = 3'd0,
        ERR_METHOD = 3'd1,
        ERR_SCHEME = 3'd2,
        ERR_REQ    = 3'd3,
        ERR_VER    = 3'd4,
        ERR_EOL    = 3'd5
    } t_err;

    typedef enum logic [1:0] {
        ROLE_NONE   = 2'd0,
        ROLE_METHOD = 2'd1,
        ROLE_TARGET = 2'd2
    } t_role;

    typedef enum logic [1:0] {
        ST_BUSY  = 2'd0,
        ST_DONE  = 2'd1,
        ST_ERROR = 2'd2
    } t_status;

    typedef struct packed {
        logic [9:0] minor;
        logic       major;
        t_err       err;
        t_status    status;
        t_role      role;
    } t_result;

    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_DEL   = 8'h7f;
    localparam logic [7:0] CH_CASE  = 8'h20;
    localparam logic [7:0] CH_SLASH = 8'h2f;
    localparam logic [7:0] CH_DOT   = 8'h2e;
    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_QUES  = 8'h3f;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_PLUS  = 8'h2b;
    localparam logic [7:0] CH_H     = 8'h48;
    localparam logic [7:0] CH_T     = 8'h54;
    localparam logic [7:0] CH_P     = 8'h50;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_1     = 8'h31;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_A     = 8'h41;
    localparam logic [7:0] CH_Z     = 8'h5a;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LZ    = 8'h7a;
    localparam logic [7:0] CH_UNDER = 8'h5f;
    localparam logic [7:0] CH_DASH  = 8'h2d;

    localparam logic [9:0] MINOR_V09  = 10'd9;
    localparam logic [9:0] MINOR_LAST = 10'd99;

    // bit n set: byte n is a usual target byte
    localparam logic [255:0] USUAL_MAP = {
        32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff,
        32'h7fffffff, 32'hffffffff, 32'h7fff37d6, 32'h00000000
    };

    function automatic logic plain_target(input logic [7:0] c);
        return USUAL_MAP[c];
    endfunction

    function automatic logic is_method(input logic [7:0] c);
        return (c >= CH_A && c <= CH_Z) || c == CH_UNDER || c == CH_DASH;
    endfunction

    function automatic logic is_ctrl(input logic [7:0] c);
        return c < CH_SP || c == CH_DEL;
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= CH_0 && c <= CH_9;
    endfunction

endpackage

// ===== sv/hrlp_parser.sv =====
// ----------------------------------------------------------------------------
// hrlp_parser
// Parser state and the one-byte transition; result reflects state after it.
// ----------------------------------------------------------------------------
module hrlp_parser import hrlp_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_en,
    input  logic       i_new_request,
    input  logic [7:0] i_data_byte,
    output t_result    o_result
);

    t_phase     r_phase, n_phase, w_phase;
    t_err       r_err, n_err, w_err;
    logic       r_major, n_major, w_major;
    logic [9:0] r_minor, n_minor, w_minor;
    t_role      w_role;
    logic [7:0] c;
    logic [7:0] w_low;
    logic [3:0] w_dig;

    always_comb begin
        c       = i_data_byte;
        w_low   = c | CH_CASE;
        w_dig   = c[3:0];
        w_phase = i_new_request ? PH_START : r_phase;
        w_err   = i_new_request ? ERR_NONE : r_err;
        w_major = i_new_request ? 1'b0 : r_major;
        w_minor = i_new_request ? 10'd0 : r_minor;
        n_phase = w_phase;
        n_err   = w_err;
        n_major = w_major;
        n_minor = w_minor;
        w_role  = ROLE_NONE;
        if (w_err == ERR_NONE && w_phase != PH_DONE) begin
            case (w_phase)
                PH_START: begin
                    if (c == CH_CR || c == CH_LF) begin
                    end else if (!is_method(c)) begin
                        n_err = ERR_METHOD;
                    end else begin
                        n_phase = PH_METHOD;
                        w_role  = ROLE_METHOD;
                    end
                end
                PH_METHOD: begin
                    if (c == CH_SP) begin
                        n_phase = PH_SP_URI;
                    end else if (!is_method(c)) begin
                        n_err = ERR_METHOD;
                    end else begin
                        w_role = ROLE_METHOD;
                    end
                end
                PH_SP_URI: begin
                    if (c == CH_SLASH) begin
                        n_phase = PH_SLASH;
                        w_role  = ROLE_TARGET;
                    end else if (w_low >= CH_LA && w_low <= CH_LZ) begin
                        n_err = ERR_SCHEME;
                    end else if (c != CH_SP) begin
                        n_err = ERR_REQ;
                    end
                end
                PH_SLASH: begin
                    if (plain_target(c)) begin
                        n_phase = PH_CHECK;
                        w_role  = ROLE_TARGET;
                    end else if (c == CH_SP) begin
                        n_phase = PH_V09;
                    end else if (c == CH_CR) begin
                        n_minor = MINOR_V09;
                        n_phase = PH_ALMOST;
                    end else if (c == CH_LF) begin
                        n_minor = MINOR_V09;
                        n_phase = PH_DONE;
                    end else if (c == CH_DOT || c == CH_PCT || c == CH_SLASH
                                 || c == CH_QUES || c == CH_HASH) begin
                        n_phase = PH_URI;
                        w_role  = ROLE_TARGET;
                    end else if (c == CH_PLUS) begin
                        w_role = ROLE_TARGET;
                    end else if (is_ctrl(c)) begin
                        n_err = ERR_REQ;
                    end else begin
                        n_phase = PH_CHECK;
                        w_role  = ROLE_TARGET;
                    end
                end
                PH_CHECK: begin
                    if (plain_target(c)) begin
                        w_role = ROLE_TARGET;
                    end else if (c == CH_SLASH) begin
                        n_phase = PH_SLASH;
                        w_role  = ROLE_TARGET;
                    end else if (c == CH_DOT || c == CH_PLUS) begin
                        w_role = ROLE_TARGET;
                    end else if (c == CH_SP) begin
                        n_phase = PH_V09;
                    end else if (c == CH_CR) begin
                        n_minor = MINOR_V09;
                        n_phase = PH_ALMOST;
                    end else if (c == CH_LF) begin
                        n_minor = MINOR_V09;
                        n_phase = PH_DONE;
                    end else if (c == CH_PCT || c == CH_QUES || c == CH_HASH) begin
                        n_phase = PH_URI;
                        w_role  = ROLE_TARGET;
                    end else if (is_ctrl(c)) begin
                        n_err = ERR_REQ;
                    end else begin
                        w_role = ROLE_TARGET;
                    end
                end
                PH_URI: begin
                    if (plain_target(c) || c == CH_HASH) begin
                        w_role = ROLE_TARGET;
                    end else if (c == CH_SP) begin
                        n_phase = PH_V09;
                    end else if (c == CH_CR) begin
                        n_minor = MINOR_V09;
                        n_phase = PH_ALMOST;
                    end else if (c == CH_LF) begin
                        n_minor = MINOR_V09;
                        n_phase = PH_DONE;
                    end else if (is_ctrl(c)) begin
                        n_err = ERR_REQ;
                    end else begin
                        w_role = ROLE_TARGET;
                    end
                end
                PH_V09: begin
                    if (c == CH_SP) begin
                    end else if (c == CH_CR) begin
                        n_minor = MINOR_V09;
                        n_phase = PH_ALMOST;
                    end else if (c == CH_LF) begin
                        n_minor = MINOR_V09;
                        n_phase = PH_DONE;
                    end else if (c == CH_H) begin
                        n_phase = PH_H;
                    end else begin
                        n_err = ERR_REQ;
                    end
                end
                PH_H: begin
                    if (c == CH_T) n_phase = PH_HT; else n_err = ERR_REQ;
                end
                PH_HT: begin
                    if (c == CH_T) n_phase = PH_HTT; else n_err = ERR_REQ;
                end
                PH_HTT: begin
                    if (c == CH_P) n_phase = PH_HTTP; else n_err = ERR_REQ;
                end
                PH_HTTP: begin
                    if (c == CH_SLASH) n_phase = PH_MAJ1; else n_err = ERR_REQ;
                end
                PH_MAJ1: begin
                    if (c < CH_1 || c > CH_9) begin
                        n_err = ERR_REQ;
                    end else if (c != CH_1) begin
                        n_err = ERR_VER;
                    end else begin
                        n_major = 1'b1;
                        n_phase = PH_MAJ;
                    end
                end
                PH_MAJ: begin
                    if (c == CH_DOT) begin
                        n_phase = PH_MIN1;
                    end else if (!is_digit(c)) begin
                        n_err = ERR_REQ;
                    end else if (w_major || w_dig > 4'd1) begin
                        n_err = ERR_VER;
                    end else begin
                        n_major = w_dig[0];
                    end
                end
                PH_MIN1: begin
                    if (!is_digit(c)) begin
                        n_err = ERR_VER;
                    end else begin
                        n_minor = {6'd0, w_dig};
                        n_phase = PH_MIN;
                    end
                end
                PH_MIN: begin
                    if (c == CH_CR) begin
                        n_phase = PH_ALMOST;
                    end else if (c == CH_LF) begin
                        n_phase = PH_DONE;
                    end else if (c == CH_SP) begin
                        n_phase = PH_SP_END;
                    end else if (!is_digit(c) || w_minor > MINOR_LAST) begin
                        n_err = ERR_REQ;
                    end else begin
                        // minor * 10 + digit, minor is at most 99 here
                        n_minor = {w_minor[6:0], 3'b000} + {w_minor[8:0], 1'b0}
                                + {6'd0, w_dig};
                    end
                end
                PH_SP_END: begin
                    if (c == CH_SP) begin
                    end else if (c == CH_CR) begin
                        n_phase = PH_ALMOST;
                    end else if (c == CH_LF) begin
                        n_phase = PH_DONE;
                    end else begin
                        n_err = ERR_REQ;
                    end
                end
                PH_ALMOST: begin
                    if (c == CH_LF) n_phase = PH_DONE; else n_err = ERR_EOL;
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        o_result.role  = w_role;
        o_result.err   = n_err;
        o_result.major = n_major;
        o_result.minor = n_minor;
        if (n_err != ERR_NONE) begin
            o_result.status = ST_ERROR;
        end else if (n_phase == PH_DONE) begin
            o_result.status = ST_DONE;
        end else begin
            o_result.status = ST_BUSY;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_START;
            r_err   <= ERR_NONE;
            r_major <= 1'b0;
            r_minor <= 10'd0;
        end else if (i_en) begin
            r_phase <= n_phase;
            r_err   <= n_err;
            r_major <= n_major;
            r_minor <= n_minor;
        end
    end

endmodule

// ===== sv/http_request_line_parser.sv =====
// ----------------------------------------------------------------------------
// http_request_line_parser
// Byte-at-a-time request line parser: role tag, status, sticky error, version.
// ----------------------------------------------------------------------------
// channel  | dir | tdata                         | tuser        | tlast
// s_axis   | in  | [7:0] data_byte               | [0] new_req  | -
// m_axis   | out | [7:0] echo_byte [9:8] status  | [1:0] role   | -
//          |     | [12:10] error_code [13] major |              |
//          |     | [23:14] minor                 |              |
//
// One beat per cycle sustained while m_axis_tready is high; a beat passes
// the input register, then the parser step into the output register.
// Reset: synchronous, active low; parser returns to request start.
// Stall on m_axis holds both stages; s_axis_tready drops only when both
// stages are full and m_axis_tready is low.
// ----------------------------------------------------------------------------
module http_request_line_parser import hrlp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tuser,   // [0] new_request
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [7:0] echo_byte, [9:8] status,
                                        // [12:10] error_code, [13] version_major,
                                        // [23:14] version_minor
    output logic [1:0]  m_axis_tuser    // [1:0] byte_role
);

    logic       r_v1, r_v2;
    logic       r_new1;
    logic [7:0] r_byte1, r_byte2;
    t_result    r_res2;
    t_result    w_res;
    logic       w_adv1, w_adv2;

    assign w_adv2 = !r_v2 || m_axis_tready;
    assign w_adv1 = !r_v1 || w_adv2;

    hrlp_parser u_parser (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_en          (r_v1 && w_adv2),
        .i_new_request (r_new1),
        .i_data_byte   (r_byte1),
        .o_result      (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (w_adv1) r_v1 <= s_axis_tvalid;
            if (w_adv2) r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv1 && s_axis_tvalid) begin
            r_new1  <= s_axis_tuser;
            r_byte1 <= s_axis_tdata;
        end
        if (w_adv2 && r_v1) begin
            r_byte2 <= r_byte1;
            r_res2  <= w_res;
        end
    end

    assign s_axis_tready = w_adv1;
    assign m_axis_tvalid = r_v2;
    assign m_axis_tuser  = r_res2.role;
    assign m_axis_tdata  = {r_res2.minor, r_res2.major, r_res2.err,
                            r_res2.status, r_byte2};

    a_err_status : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> ((m_axis_tdata[9:8] == ST_ERROR) == (m_axis_tdata[12:10] != ERR_NONE)))
        else $error("status and error code disagree");

    a_role_busy : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser != ROLE_NONE) |-> m_axis_tdata[9:8] == ST_BUSY)
        else $error("byte tagged after line finished");

    a_minor_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[23:14] <= 10'd999)
        else $error("minor version out of range");

    a_in_capture : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> r_v1)
        else $error("accepted beat lost at input register");

endmodule
